@@ hdl/zpt_pkg.sv @@
package zpt_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int PRICE_BITS = 32;
	localparam int TIME_BITS  = 64;
	localparam int CFG_BITS   = 5;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int WIN_W      = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

	localparam logic [CFG_BITS-1:0] WIN_RESET = CFG_BITS'(5);

	typedef logic [1:0] class_t;
	localparam class_t CLASS_MIXED_UP   = 2'd0;
	localparam class_t CLASS_MIXED_DOWN = 2'd1;
	localparam class_t CLASS_PEAK       = 2'd2;
	localparam class_t CLASS_TROUGH     = 2'd3;

	typedef struct packed {
		logic gt;
		logic lt;
	} cmp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT_FIRST,
		ST_EMIT_SECOND
	} state_t;

endpackage

@@ hdl/zpt_cell.sv @@
module zpt_cell import zpt_pkg::*; (
	input  logic                  clk,
	input  logic                  shift_en,
	input  logic [PRICE_BITS-1:0] shift_in,
	input  logic [PRICE_BITS-1:0] price,
	output logic [PRICE_BITS-1:0] entry,
	output cmp_t                  cmp
);

	logic [PRICE_BITS-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= shift_in;
		end
	end

	assign entry  = entry_q;
	assign cmp.gt = price > entry_q;
	assign cmp.lt = price < entry_q;

endmodule

@@ hdl/swing_pivot_zigzag_tracker.sv @@
// Latency: a request is taken in IDLE, classed and applied to the pivot in the
// next cycle, and its first result is offered the cycle after that.
// Flow: one request at a time; in_ready is high only in IDLE, which is reached
// again only after the request's results are taken while out_ready is high.
// Reset: arst_n clears the history count, pivot state and handshakes at once;
// window_length returns to 5. History entries are masked by the count.
module swing_pivot_zigzag_tracker import zpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_BITS-1:0]   cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  candle_valid,
	input  logic [PRICE_BITS-1:0] close_price,
	input  logic [TIME_BITS-1:0]  candle_time,
	input  logic                  end_of_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TIME_BITS-1:0]  point_time,
	output logic [PRICE_BITS-1:0] point_price,
	output logic                  is_final_point,
	output logic                  last_of_run
);

	state_t state_q, state_d;

	logic [CFG_BITS-1:0] window_length_q;
	logic [CNT_W-1:0]    hist_count_q;

	logic [PRICE_BITS-1:0] hist [MAX_WINDOW];
	cmp_t                  cmp  [MAX_WINDOW];
	logic                  accept;

	// request registers
	logic                  valid_s1, eod_s1, classed_s1, gt_any_s1, lt_any_s1, lt0_s1;
	logic [PRICE_BITS-1:0] price_s1;
	logic [TIME_BITS-1:0]  time_s1;

	// pivot
	logic                  pivot_present_q, dir_up_q;
	logic [PRICE_BITS-1:0] pivot_price_q;
	logic [TIME_BITS-1:0]  pivot_stamp_q;
	class_t                pivot_class_q;

	// results
	logic                  out_valid_q, final_q, last_q;
	logic [TIME_BITS-1:0]  out_time_q, spare_time_q;
	logic [PRICE_BITS-1:0] out_price_q, spare_price_q;

	assign accept = in_valid && in_ready;

	// history row
	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		logic [PRICE_BITS-1:0] sin;
		if (j == 0) begin : g_head
			assign sin = close_price;
		end else begin : g_body
			assign sin = hist[j-1];
		end
		zpt_cell u_cell (
			.clk      (clk),
			.shift_en (accept && candle_valid),
			.shift_in (sin),
			.price    (close_price),
			.entry    (hist[j]),
			.cmp      (cmp[j])
		);
	end

	// window mask: entries nearer than min(count, window), window clamped to 1..MAX_WINDOW
	logic [WIN_W-1:0]      win_eff, cnt_ext, n_eff;
	logic [MAX_WINDOW-1:0] mask, gt_vec, lt_vec;

	always_comb begin
		cnt_ext = WIN_W'(hist_count_q);
		if (window_length_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (WIN_W'(window_length_q) > WIN_W'(MAX_WINDOW)) begin
			win_eff = WIN_W'(MAX_WINDOW);
		end else begin
			win_eff = WIN_W'(window_length_q);
		end
		n_eff = (cnt_ext < win_eff) ? cnt_ext : win_eff;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			mask[j]   = WIN_W'(j) < n_eff;
			gt_vec[j] = cmp[j].gt;
			lt_vec[j] = cmp[j].lt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			window_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_count_q <= '0;
		end else if (accept) begin
			if (end_of_data) begin
				hist_count_q <= '0;
			end else if (candle_valid && hist_count_q != CNT_W'(MAX_WINDOW)) begin
				hist_count_q <= hist_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			valid_s1   <= candle_valid;
			eod_s1     <= end_of_data;
			price_s1   <= close_price;
			time_s1    <= candle_time;
			classed_s1 <= hist_count_q != '0;
			gt_any_s1  <= |(gt_vec & mask);
			lt_any_s1  <= |(lt_vec & mask);
			lt0_s1     <= cmp[0].lt;
		end
	end

	// An equal close copies the verdict before it (up if nearest), so the run is
	// all up when nothing is lower, and all down when the nearest is lower and
	// nothing is higher.
	class_t cls;
	always_comb begin
		if (!lt_any_s1) begin
			cls = CLASS_PEAK;
		end else if (lt0_s1 && !gt_any_s1) begin
			cls = CLASS_TROUGH;
		end else if (!lt0_s1) begin
			cls = CLASS_MIXED_UP;
		end else begin
			cls = CLASS_MIXED_DOWN;
		end
	end

	// zigzag update
	logic                  pp_d, dir_d, emit_turn, emit_flush;
	logic [PRICE_BITS-1:0] ppr_d;
	logic [TIME_BITS-1:0]  pst_d;
	class_t                pcl_d;

	always_comb begin
		pp_d      = pivot_present_q;
		dir_d     = dir_up_q;
		ppr_d     = pivot_price_q;
		pst_d     = pivot_stamp_q;
		pcl_d     = pivot_class_q;
		emit_turn = 1'b0;
		if (valid_s1 && classed_s1) begin
			if (!pivot_present_q) begin
				pp_d  = 1'b1;
				ppr_d = price_s1;
				pst_d = time_s1;
				pcl_d = cls;
				dir_d = cls == CLASS_PEAK;
			end else if (cls == CLASS_PEAK || cls == CLASS_TROUGH) begin
				if (cls == pivot_class_q) begin
					if (dir_up_q ? (price_s1 >= pivot_price_q)
					             : (price_s1 <= pivot_price_q)) begin
						ppr_d = price_s1;
						pst_d = time_s1;
					end
				end else begin
					emit_turn = 1'b1;
					dir_d     = !dir_up_q;
					ppr_d     = price_s1;
					pst_d     = time_s1;
					pcl_d     = cls;
				end
			end
		end
		emit_flush = eod_s1 && pp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_present_q <= 1'b0;
			dir_up_q        <= 1'b0;
			pivot_price_q   <= '0;
			pivot_stamp_q   <= '0;
			pivot_class_q   <= CLASS_MIXED_UP;
		end else if (state_q == ST_CALC) begin
			if (eod_s1) begin
				pivot_present_q <= 1'b0;
				dir_up_q        <= 1'b0;
				pivot_price_q   <= '0;
				pivot_stamp_q   <= '0;
				pivot_class_q   <= CLASS_MIXED_UP;
			end else begin
				pivot_present_q <= pp_d;
				dir_up_q        <= dir_d;
				pivot_price_q   <= ppr_d;
				pivot_stamp_q   <= pst_d;
				pivot_class_q   <= pcl_d;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (emit_turn || emit_flush) begin
					state_d = ST_EMIT_FIRST;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_FIRST: begin
				if (out_ready) begin
					state_d = last_q ? ST_IDLE : ST_EMIT_SECOND;
				end
			end
			ST_EMIT_SECOND: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_CALC) begin
			out_valid_q <= emit_turn || emit_flush;
		end else if (out_valid_q && out_ready && last_q) begin
			out_valid_q <= 1'b0;
		end
	end

	// turn point goes first; a flush that comes with a turn follows from the spare slot
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			out_time_q    <= emit_turn ? pivot_stamp_q : pst_d;
			out_price_q   <= emit_turn ? pivot_price_q : ppr_d;
			final_q       <= !emit_turn;
			last_q        <= !(emit_turn && emit_flush);
			spare_time_q  <= pst_d;
			spare_price_q <= ppr_d;
		end else if (state_q == ST_EMIT_FIRST && out_ready && !last_q) begin
			out_time_q  <= spare_time_q;
			out_price_q <= spare_price_q;
			final_q     <= 1'b1;
			last_q      <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign point_time     = out_time_q;
	assign point_price    = out_price_q;
	assign is_final_point = final_q;
	assign last_of_run    = last_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import zpt_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 320;
	localparam int SETTLE       = 6;

	typedef struct {
		logic [TIME_BITS-1:0]  stamp;
		logic [PRICE_BITS-1:0] price;
		logic                  final_pt;
		logic                  last;
	} point_t;

	class pivot_scoreboard;
		point_t                pending_points[$];
		logic [PRICE_BITS-1:0] closes[MAX_WINDOW];
		int unsigned           close_count;
		bit                    has_pivot;
		logic [PRICE_BITS-1:0] pivot_px;
		logic [TIME_BITS-1:0]  pivot_ts;
		class_t                pivot_cls;
		bit                    heading_up;
		logic [CFG_BITS-1:0]   window;
		int unsigned           errors;

		function new();
			window = WIN_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (closes[j]) closes[j] = '0;
			close_count = 0;
			has_pivot = 0;
			pivot_px = '0;
			pivot_ts = '0;
			pivot_cls = CLASS_MIXED_UP;
			heading_up = 0;
		endfunction

		// nearest first; a tie repeats the previous verdict, or counts as up at first
		function class_t class_of(logic [PRICE_BITS-1:0] price, int unsigned n);
			bit nearest, prev, v, same;
			nearest = 1;
			prev = 1;
			same = 1;
			v = 1;
			for (int j = 0; j < n; j++) begin
				if (price > closes[j])
					v = 1;
				else if (price < closes[j])
					v = 0;
				else
					v = (j == 0) ? 1'b1 : prev;
				if (j == 0)
					nearest = v;
				else if (v != nearest)
					same = 0;
				prev = v;
			end
			if (same)
				return nearest ? CLASS_PEAK : CLASS_TROUGH;
			return nearest ? CLASS_MIXED_UP : CLASS_MIXED_DOWN;
		endfunction

		function void take_candle(logic vld, logic [PRICE_BITS-1:0] price,
				logic [TIME_BITS-1:0] stamp, logic eod);
			point_t      run[2];
			int unsigned nrun;
			int unsigned w, n;
			class_t      cls;
			nrun = 0;
			if (vld) begin
				w = (window == 0) ? 1 : ((window > MAX_WINDOW) ? MAX_WINDOW : window);
				n = (close_count < w) ? close_count : w;
				if (n > 0) begin
					cls = class_of(price, n);
					if (!has_pivot) begin
						has_pivot = 1;
						pivot_px = price;
						pivot_ts = stamp;
						pivot_cls = cls;
						heading_up = (cls == CLASS_PEAK);
					end else if (cls == CLASS_PEAK || cls == CLASS_TROUGH) begin
						if (cls == pivot_cls) begin
							if (heading_up ? (price >= pivot_px) : (price <= pivot_px)) begin
								pivot_px = price;
								pivot_ts = stamp;
							end
						end else begin
							run[nrun] = '{pivot_ts, pivot_px, 1'b0, 1'b0};
							nrun++;
							heading_up = !heading_up;
							pivot_px = price;
							pivot_ts = stamp;
							pivot_cls = cls;
						end
					end
				end
				for (int j = MAX_WINDOW - 1; j > 0; j--)
					closes[j] = closes[j-1];
				closes[0] = price;
				if (close_count < MAX_WINDOW)
					close_count++;
			end
			if (eod) begin
				if (has_pivot) begin
					run[nrun] = '{pivot_ts, pivot_px, 1'b1, 1'b0};
					nrun++;
				end
				clear();
			end
			if (nrun > 0)
				run[nrun-1].last = 1'b1;
			for (int i = 0; i < nrun; i++)
				pending_points.insert(pending_points.size(), run[i]);
		endfunction

		function void check_point(logic [TIME_BITS-1:0] stamp, logic [PRICE_BITS-1:0] price,
				logic fin, logic last);
			point_t p;
			if (pending_points.size() == 0) begin
				$error("unexpected point: time %h price %h", stamp, price);
				errors++;
				return;
			end
			p = pending_points.pop_front();
			if (stamp !== p.stamp) begin
				$error("point_time: expected %h, got %h", p.stamp, stamp);
				errors++;
			end
			if (price !== p.price) begin
				$error("point_price: expected %h, got %h", p.price, price);
				errors++;
			end
			if (fin !== p.final_pt) begin
				$error("is_final_point: expected %b, got %b", p.final_pt, fin);
				errors++;
			end
			if (last !== p.last) begin
				$error("last_of_run: expected %b, got %b", p.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_BITS-1:0]   cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  candle_valid = 1'b0;
	logic [PRICE_BITS-1:0] close_price = '0;
	logic [TIME_BITS-1:0]  candle_time = '0;
	logic                  end_of_data = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TIME_BITS-1:0]  point_time;
	logic [PRICE_BITS-1:0] point_price;
	logic                  is_final_point;
	logic                  last_of_run;

	pivot_scoreboard board;
	bit              calm = 0;
	bit              gaps_on = 1;
	int unsigned     cycles = 0;

	swing_pivot_zigzag_tracker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.candle_valid   (candle_valid),
		.close_price    (close_price),
		.candle_time    (candle_time),
		.end_of_data    (end_of_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.point_time     (point_time),
		.point_price    (point_price),
		.is_final_point (is_final_point),
		.last_of_run    (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// results first: a request's own results never share its acceptance edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_point(point_time, point_price, is_final_point, last_of_run);
		if (arst_n && in_valid && in_ready)
			board.take_candle(candle_valid, close_price, candle_time, end_of_data);
	end

	initial begin
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(50, 200)) @(posedge clk);
			else
				repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!calm) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	task automatic send_candle(input logic vld, input logic [PRICE_BITS-1:0] px,
			input logic [TIME_BITS-1:0] ts, input logic eod);
		if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		candle_valid <= vld;
		close_price <= px;
		candle_time <= ts;
		end_of_data <= eod;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic set_window(input logic [CFG_BITS-1:0] value);
		in_valid <= 1'b0;
		// let the last request reach the scoreboard and the block, then drain
		repeat (SETTLE) @(posedge clk);
		while (board.pending_points.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.window = value;
	endtask

	task automatic directed_part();
		send_candle(1'b1, 32'd1000, 64'd0, 1'b0);       // no history yet
		send_candle(1'b1, 32'd2000, 64'd1, 1'b0);       // first pivot, peak
		send_candle(1'b1, 32'd2000, 64'd2, 1'b0);       // tie replaces pivot
		send_candle(1'b1, 32'd500, 64'd3, 1'b0);        // trough, emit
		send_candle(1'b1, 32'd500, 64'd4, 1'b0);        // mixed, nearest up
		send_candle(1'b0, $urandom, 64'd5, 1'b0);
		send_candle(1'b1, 32'd0, 64'd6, 1'b0);
		send_candle(1'b1, '1, '1, 1'b0);
		send_candle(1'b0, '1, 64'd7, 1'b1);             // flush on skipped candle
		send_candle(1'b0, 32'd0, 64'd8, 1'b1);          // nothing held
		send_candle(1'b1, 32'd300, 64'd9, 1'b1);
		send_candle(1'b1, 32'd100, 64'd10, 1'b0);
		send_candle(1'b1, 32'd50, 64'd11, 1'b0);
		send_candle(1'b1, 32'd200, 64'd12, 1'b1);       // emit and flush together
		send_candle(1'b1, 32'd10, 64'd13, 1'b0);
		send_candle(1'b1, 32'd20, 64'd14, 1'b0);
		send_candle(1'b1, 32'd30, 64'd15, 1'b0);
		send_candle(1'b1, 32'd25, 64'd16, 1'b0);        // mixed, nearest down
		send_candle(1'b1, 32'd40, 64'd17, 1'b0);
		send_candle(1'b1, 32'd35, 64'd18, 1'b1);
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned           sent;
		int unsigned           len;
		int unsigned           stride;
		logic [PRICE_BITS-1:0] px;
		logic [TIME_BITS-1:0]  ts;
		bit                    rising, noise, vld, eod;
		sent = 0;
		while (sent < quota) begin
			len = $urandom_range(3, 60);
			noise = ($urandom_range(0, 9) == 0);
			gaps_on = ($urandom_range(0, 9) < 7);
			case ($urandom_range(0, 2))
				0: px = $urandom;
				1: px = $urandom_range(0, 40);
				default: px = 32'hFFFF_FFFF - $urandom_range(0, 40);
			endcase
			stride = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 5000);
			rising = $urandom_range(0, 1);
			ts = {$urandom, $urandom};
			for (int k = 0; k < len; k++) begin
				if (noise) begin
					vld = ($urandom_range(0, 3) != 0);
					px = $urandom;
					eod = ($urandom_range(0, 19) == 0);
				end else begin
					vld = ($urandom_range(0, 11) != 0);
					if ($urandom_range(0, 3) == 0)
						rising = !rising;
					if (vld)
						px = rising ? px + $urandom_range(0, stride) : px - $urandom_range(0, stride);
					eod = (k == len - 1) && ($urandom_range(0, 4) != 0);
				end
				ts = ts + $urandom_range(1, 900);
				send_candle(vld, vld ? px : $urandom, ts, eod);
				if (vld || eod)
					sent++;
			end
		end
	endtask

	initial begin
		int windows[6];
		windows = '{16, 1, 0, 31, 0, 5};
		windows[4] = $urandom_range(2, 30);
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		foreach (windows[i]) begin
			set_window(CFG_BITS'(windows[i]));
			if (i == 5)
				calm = 1;
			random_phase(PHASE_ITEMS);
		end
		in_valid <= 1'b0;
		repeat (SETTLE) @(posedge clk);
		while (board.pending_points.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending_points.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
